// ----- hw/rtl/afr_pkg.sv -----
// Package for the frame receiver: item, result and job types, codes and constants.
// No dependencies; every other file imports it.
`timescale 1ns / 1ps

package afr_pkg;

	localparam int AFR_PAYLOAD_DEPTH = 16;
	localparam int AFR_QUEUE_DEPTH   = 2;

	localparam logic [7:0]  START_BYTE     = 8'h7E;
	localparam logic [15:0] TIMEOUT_RESET  = 16'd150;
	localparam logic [15:0] IDLE_MAX       = 16'hFFFF;

	// APB register map: index taken from paddr[2]
	localparam int   APB_ADDR_W  = 3;
	localparam logic REG_TIMEOUT = 1'b0;

	typedef enum logic [1:0] {
		ST_GOOD     = 2'd0,
		ST_BAD_SUM  = 2'd1,
		ST_TIMEOUT  = 2'd2,
		ST_TOO_LONG = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		PH_START = 2'd0,
		PH_MSB   = 2'd1,
		PH_LSB   = 2'd2,
		PH_DATA  = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_STAT,
		BK_BYTES
	} bk_state_t;

	typedef struct packed {
		logic       func;
		logic [7:0] rx_byte;
	} item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        has_byte;
		logic [7:0]  payload_byte;
		logic [3:0]  byte_index;
		logic [15:0] frame_length;
		logic        last;
	} result_t;

	// one finished frame or error, handed from front to back
	typedef struct packed {
		status_t     status;
		logic [15:0] length;
	} job_t;

endpackage

// ----- hw/rtl/afr_front.sv -----
// Front end: frame parser, checksum and timeout tracking; writes payload store, pushes jobs.
// Depends on afr_pkg.
`timescale 1ns / 1ps

module afr_front
	import afr_pkg::*;
#(
	parameter int PAYLOAD_DEPTH = AFR_PAYLOAD_DEPTH,
	localparam int AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [15:0]   timeout_ticks,
	input  logic          item_valid,
	output logic          item_stall,
	input  item_t         item,
	output logic          job_push,
	output job_t          job,
	input  logic          queue_full,
	input  logic          store_busy,
	output logic          store_we,
	output logic [AW-1:0] store_waddr,
	output logic [7:0]    store_wdata
);

	localparam logic [15:0] DEPTH_W = 16'(PAYLOAD_DEPTH);

	phase_t      phase_q, phase_d;
	logic [15:0] length_q, length_d;
	logic [15:0] taken_q, taken_d;
	logic [7:0]  sum_q, sum_d;
	logic [15:0] idle_q, idle_d;

	logic        accept;
	logic [15:0] idle_inc;
	logic        timeout_hit;
	logic        in_payload;
	logic        is_check;
	logic        writes_store;
	logic        gives_result;
	status_t     check_status;

	// classify the item at the port
	always_comb begin
		idle_inc     = (idle_q == IDLE_MAX) ? idle_q : idle_q + 16'd1;
		timeout_hit  = item.func && (phase_q != PH_START) && (idle_inc >= timeout_ticks);
		in_payload   = !item.func && (phase_q == PH_DATA) && (taken_q < length_q);
		is_check     = !item.func && (phase_q == PH_DATA) && !(taken_q < length_q);
		writes_store = in_payload && (taken_q < DEPTH_W);
		gives_result = timeout_hit || is_check;
		priority if (length_q > DEPTH_W) begin
			check_status = ST_TOO_LONG;
		end else if ((~sum_q) != item.rx_byte) begin
			check_status = ST_BAD_SUM;
		end else begin
			check_status = ST_GOOD;
		end
	end

	// hold a result while the queue is full; hold a store write while the back reads it
	assign item_stall = (gives_result && queue_full) || (writes_store && store_busy);
	assign accept     = item_valid && !item_stall;

	// next state
	always_comb begin
		phase_d  = phase_q;
		length_d = length_q;
		taken_d  = taken_q;
		sum_d    = sum_q;
		idle_d   = idle_q;
		if (accept) begin
			if (item.func) begin
				if (phase_q != PH_START) begin
					if (timeout_hit) begin
						phase_d = PH_START;
						taken_d = '0;
						sum_d   = '0;
						idle_d  = '0;
					end else begin
						idle_d = idle_inc;
					end
				end
			end else begin
				idle_d = '0;
				unique case (phase_q)
					PH_START: begin
						if (item.rx_byte == START_BYTE) begin
							phase_d  = PH_MSB;
							length_d = '0;
							taken_d  = '0;
							sum_d    = '0;
						end
					end
					PH_MSB: begin
						length_d = {item.rx_byte, 8'h00};
						phase_d  = PH_LSB;
					end
					PH_LSB: begin
						length_d = {length_q[15:8], item.rx_byte};
						phase_d  = PH_DATA;
					end
					PH_DATA: begin
						if (in_payload) begin
							sum_d   = sum_q + item.rx_byte;
							taken_d = taken_q + 16'd1;
						end else begin
							phase_d = PH_START;
							taken_d = '0;
							sum_d   = '0;
						end
					end
				endcase
			end
		end
	end

	// outputs
	always_comb begin
		job_push    = accept && gives_result;
		job.status  = timeout_hit ? ST_TIMEOUT : check_status;
		job.length  = length_q;
		store_we    = accept && writes_store;
		store_waddr = taken_q[AW-1:0];
		store_wdata = item.rx_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_START;
			length_q <= '0;
			taken_q  <= '0;
			sum_q    <= '0;
			idle_q   <= '0;
		end else begin
			phase_q  <= phase_d;
			length_q <= length_d;
			taken_q  <= taken_d;
			sum_q    <= sum_d;
			idle_q   <= idle_d;
		end
	end

	a_start_clean: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_START |-> taken_q == 16'd0 && sum_q == 8'd0 && idle_q == 16'd0)
		else $error("front: counters not cleared while hunting for start");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		job_push |-> !queue_full)
		else $error("front: job pushed into full queue");

	a_write_free: assert property (@(posedge clk) disable iff (!arst_n)
		store_we |-> !store_busy)
		else $error("front: payload store written while back reads it");

endmodule

// ----- hw/rtl/afr_queue.sv -----
// Short job queue between front and back ends.
// Depends on afr_pkg.
`timescale 1ns / 1ps

module afr_queue
	import afr_pkg::*;
#(
	parameter int QUEUE_DEPTH = AFR_QUEUE_DEPTH,
	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
	localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output job_t pop_job,
	output logic pop_valid
);

	localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
	localparam logic [PW-1:0] LAST_P  = PW'(QUEUE_DEPTH - 1);

	job_t          slot_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_pop;

	assign full      = (count_q == DEPTH_C);
	assign pop_valid = (count_q != '0);
	assign pop_job   = slot_q[rd_ptr_q];
	assign do_pop    = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_P) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_P) ? '0 : rd_ptr_q + PW'(1);
			end
			priority if (push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// ----- hw/rtl/afr_back.sv -----
// Back end: payload store, job sequencer and result output register.
// Depends on afr_pkg.
`timescale 1ns / 1ps

module afr_back
	import afr_pkg::*;
#(
	parameter int PAYLOAD_DEPTH = AFR_PAYLOAD_DEPTH,
	localparam int AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          job_valid,
	input  job_t          job,
	output logic          job_pop,
	output logic          busy,
	input  logic          store_we,
	input  logic [AW-1:0] store_waddr,
	input  logic [7:0]    store_wdata,
	output logic          result_valid,
	input  logic          result_stall,
	output result_t       result
);

	localparam logic [15:0] DEPTH_W = 16'(PAYLOAD_DEPTH);

	logic [7:0]    store_mem [PAYLOAD_DEPTH];

	bk_state_t     state_q, state_d;
	job_t          job_q;
	logic [AW-1:0] idx_q;
	logic          issued_all_q;
	logic          rd_valid_s1;
	logic [AW-1:0] rd_idx_s1;
	logic          rd_last_s1;
	logic [7:0]    rd_data_s1;
	logic          out_valid_q;
	result_t       out_q;

	logic          out_free;
	logic          rd_en;
	logic          load_stat;
	logic          load_byte;
	logic          last_issue;
	logic [15:0]   rd_idx_w;

	assign out_free   = !out_valid_q || !result_stall;
	assign last_issue = (16'(idx_q) + 16'd1) == job_q.length;
	assign rd_idx_w   = 16'(rd_idx_s1);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (job_valid) begin
					state_d = (job.status != ST_GOOD || job.length == 16'd0) ? BK_STAT : BK_BYTES;
				end
			end
			BK_STAT: begin
				if (out_free) begin
					state_d = BK_IDLE;
				end
			end
			BK_BYTES: begin
				if (rd_valid_s1 && rd_last_s1 && out_free) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		job_pop   = (state_q == BK_IDLE) && job_valid;
		load_stat = (state_q == BK_STAT) && out_free;
		rd_en     = (state_q == BK_BYTES) && !issued_all_q && !rd_valid_s1 && out_free;
		load_byte = rd_valid_s1 && out_free;
		busy      = (state_q != BK_IDLE);
	end

	always_ff @(posedge clk) begin
		if (store_we) begin
			store_mem[store_waddr] <= store_wdata;
		end
		if (rd_en) begin
			rd_data_s1 <= store_mem[idx_q];
			rd_idx_s1  <= idx_q;
			rd_last_s1 <= last_issue;
		end
		if (job_pop) begin
			job_q <= job;
		end
		if (load_stat) begin
			out_q <= '{status: job_q.status, has_byte: 1'b0, payload_byte: 8'h00,
			           byte_index: 4'h0, frame_length: job_q.length, last: 1'b1};
		end else if (load_byte) begin
			out_q <= '{status: ST_GOOD, has_byte: 1'b1, payload_byte: rd_data_s1,
			           byte_index: rd_idx_w[3:0], frame_length: job_q.length,
			           last: rd_last_s1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= BK_IDLE;
			idx_q        <= '0;
			issued_all_q <= 1'b0;
			rd_valid_s1  <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (job_pop) begin
				idx_q        <= '0;
				issued_all_q <= 1'b0;
			end else if (rd_en) begin
				idx_q        <= idx_q + AW'(1);
				issued_all_q <= last_issue;
			end
			// read and load exclude each other: a read waits for stage 1 to empty
			if (rd_en) begin
				rd_valid_s1 <= 1'b1;
			end else if (load_byte) begin
				rd_valid_s1 <= 1'b0;
			end
			if (load_stat || load_byte) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	a_read_gap: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> !rd_valid_s1)
		else $error("back: read issued over a pending read");

	a_read_state: assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid_s1 |-> state_q == BK_BYTES)
		else $error("back: read data pending outside byte phase");

	a_byte_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_BYTES |-> job_q.length != 16'd0 && job_q.length <= DEPTH_W
		&& job_q.status == ST_GOOD)
		else $error("back: byte phase entered with an unfit job");

endmodule

// ----- hw/rtl/api_frame_receiver.sv -----
// Frame receiver: each accepted byte or tick is absorbed by the front end; a status
// result passes through the job queue, the back end's sequencer and the result output
// register; payload bytes of a good frame are read one at a time, each by one store read
// and then the output register. Payload bytes are held off while the back end still
// reads the store. Reset clears all control state and sets timeout_ticks to 150; the
// payload store is left as is, with no clearing pass.
`timescale 1ns / 1ps

module api_frame_receiver
	import afr_pkg::*;
#(
	parameter int PAYLOAD_DEPTH = AFR_PAYLOAD_DEPTH,
	parameter int QUEUE_DEPTH   = AFR_QUEUE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  item_t                 item,
	output logic                  result_valid,
	input  logic                  result_stall,
	output result_t               result
);

	localparam int AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;

	logic [15:0]   timeout_q;
	logic          job_push;
	job_t          push_job;
	logic          queue_full;
	logic          job_pop;
	job_t          pop_job;
	logic          job_valid;
	logic          back_busy;
	logic          store_busy;
	logic          store_we;
	logic [AW-1:0] store_waddr;
	logic [7:0]    store_wdata;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_TIMEOUT) ? {16'h0000, timeout_q} : 32'h0000_0000;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_TIMEOUT) begin
			timeout_q <= pwdata[15:0];
		end
	end

	assign store_busy = back_busy || job_valid;

	afr_front #(.PAYLOAD_DEPTH(PAYLOAD_DEPTH)) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.timeout_ticks (timeout_q),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.item          (item),
		.job_push      (job_push),
		.job           (push_job),
		.queue_full    (queue_full),
		.store_busy    (store_busy),
		.store_we      (store_we),
		.store_waddr   (store_waddr),
		.store_wdata   (store_wdata)
	);

	afr_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (job_push),
		.push_job  (push_job),
		.full      (queue_full),
		.pop       (job_pop),
		.pop_job   (pop_job),
		.pop_valid (job_valid)
	);

	afr_back #(.PAYLOAD_DEPTH(PAYLOAD_DEPTH)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_valid    (job_valid),
		.job          (pop_job),
		.job_pop      (job_pop),
		.busy         (back_busy),
		.store_we     (store_we),
		.store_waddr  (store_waddr),
		.store_wdata  (store_wdata),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule
